[rtl/scc_pkg.sv]
// Shared types, codes and helpers for the strongly connected components block.
// Used by the controller, the datapath, the top level and the checker.
package scc_pkg;

  localparam int VERTEX_LIMIT         = 32;
  localparam int DEFAULT_MAX_VERTICES = 32;

  localparam logic REQ_WRITE   = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [4:0]  row_index;
    logic [31:0] row_bits;
  } item_word_t;

  typedef struct packed {
    logic [4:0] vertex;
    logic [4:0] component;
    logic [5:0] component_total;
    logic       last;
  } result_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS1,
    ST_PASS2,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ROW_WRITE,
    OP_LOAD,
    OP_WALK_T,
    OP_INIT2,
    OP_WALK,
    OP_EMIT_INIT,
    OP_EMIT
  } op_t;

  typedef struct packed {
    logic pass1_done;
    logic pass2_done;
    logic out_free;
    logic emit_last;
  } status_t;

  // Lowest set bit: {found, index}. Isolate it, then encode with an OR tree.
  function automatic logic [5:0] first_set(input logic [31:0] x);
    logic [31:0] low;
    logic [4:0]  idx;
    low = x & (~x + 32'd1);
    idx = '0;
    for (int i = 0; i < 32; i++) begin
      if (low[i]) idx = idx | 5'(i);
    end
    return {|x, idx};
  endfunction

endpackage

[rtl/strongly_connected_components.sv]
// Top level of the strongly connected components block (Kosaraju, two passes).
// Depends on scc_pkg, scc_ctrl and scc_datapath.
//
//  channel  | signals                          | word
//  ---------+----------------------------------+----------------------------
//  item     | item_valid / item_ready / item   | item_word_t: row write or compute
//  result   | result_valid / result_ready / .. | result_word_t: one per vertex
//  config   | cfg_write / cfg_data             | vertex_count, no read-back
//
// A row write leaves the block idle, ready for the next item. A compute runs the
// transposed pass, then the labeling pass (plus a skip step per finish-order
// root already labeled), then emits one result word per vertex in use; a stalled
// result holds the emit sequence. Each walk step pushes or pops the stack as the
// neighbor select and lowest-bit search decide, or skips a labeled root. Reset
// is synchronous; it clears the graph and vertex_count returns to 32.
module strongly_connected_components
  import scc_pkg::*;
#(
  parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_ready,
  input  item_word_t   item,
  output logic         result_valid,
  input  logic         result_ready,
  output result_word_t result,
  input  logic         cfg_write,
  input  logic [5:0]   cfg_data
);

  op_t     op;
  status_t status;

  scc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_req_type (item.req_type),
    .item_ready    (item_ready),
    .status        (status),
    .op            (op)
  );

  scc_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .status       (status),
    .item         (item),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

[rtl/scc_ctrl.sv]
// Sequencer for the two depth-first passes and the result burst.
// Depends on scc_pkg; drives scc_datapath through op_t and reads status_t.
module scc_ctrl
  import scc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_req_type,
  output logic    item_ready,
  input  status_t status,
  output op_t     op
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid && item_req_type == REQ_COMPUTE) state_next = ST_PASS1;
      end
      ST_PASS1: begin
        if (status.pass1_done) state_next = ST_PASS2;
      end
      ST_PASS2: begin
        if (status.pass2_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free && status.emit_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    op         = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          op = (item_req_type == REQ_COMPUTE) ? OP_LOAD : OP_ROW_WRITE;
        end
      end
      ST_PASS1: begin
        op = status.pass1_done ? OP_INIT2 : OP_WALK_T;
      end
      ST_PASS2: begin
        op = status.pass2_done ? OP_EMIT_INIT : OP_WALK;
      end
      ST_EMIT: begin
        if (status.out_free) op = OP_EMIT;
      end
      default: op = OP_NONE;
    endcase
  end

endmodule

[rtl/scc_datapath.sv]
// Graph storage, walk stack, finish order, labels and the result register.
// Depends on scc_pkg; each op from scc_ctrl performs one step per cycle.
module scc_datapath
  import scc_pkg::*;
#(
  parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES
) (
  input  logic         clk,
  input  logic         rst,
  input  op_t          op,
  output status_t      status,
  input  item_word_t   item,
  input  logic         cfg_write,
  input  logic [5:0]   cfg_data,
  input  logic         result_ready,
  output logic         result_valid,
  output result_word_t result
);

  localparam int         VCAP   = (MAX_VERTICES < VERTEX_LIMIT) ? MAX_VERTICES : VERTEX_LIMIT;
  localparam logic [5:0] VCAP_W = 6'(VCAP);

  logic [31:0] adj [VERTEX_LIMIT];
  logic [4:0]  stack [VERTEX_LIMIT];
  logic [4:0]  finish [VERTEX_LIMIT];
  logic [4:0]  comp [VERTEX_LIMIT];

  logic [5:0]  vertex_count;
  logic [5:0]  n;
  logic [31:0] nmask;
  logic [31:0] visited;
  logic [4:0]  top;
  logic [5:0]  depth;
  logic [5:0]  fin;
  logic [5:0]  ptr;
  logic [5:0]  counter;
  logic [4:0]  label;
  logic [4:0]  idx;

  logic [5:0]  n_clamp;
  logic [31:0] nmask_clamp;
  logic [31:0] col;
  logic [31:0] open_set;
  logic [5:0]  open_pick;
  logic [5:0]  root_pick;
  logic [4:0]  cand;
  logic [4:0]  below_top;
  logic [4:0]  n_last;
  logic        row_ok;

  always_comb begin
    if (vertex_count == 6'd0) begin
      n_clamp = 6'd1;
    end else if (vertex_count > VCAP_W) begin
      n_clamp = VCAP_W;
    end else begin
      n_clamp = vertex_count;
    end
    nmask_clamp = (n_clamp == 6'd32) ? '1 : ((32'd1 << n_clamp[4:0]) - 32'd1);
  end

  always_comb begin
    for (int k = 0; k < VERTEX_LIMIT; k++) begin
      col[k] = adj[k][top];
    end
  end

  assign open_set  = ((op == OP_WALK_T) ? col : adj[top]) & nmask & ~visited;
  assign open_pick = first_set(open_set);
  assign root_pick = first_set(nmask & ~visited);
  assign cand      = finish[5'(ptr - 6'd1)];
  assign below_top = stack[5'(depth - 6'd2)];
  assign n_last    = 5'(n - 6'd1);
  assign row_ok    = {1'b0, item.row_index} < VCAP_W;

  assign status.pass1_done = (depth == 6'd0) && !root_pick[5];
  assign status.pass2_done = (depth == 6'd0) && (ptr == 6'd0);
  assign status.out_free   = !result_valid || result_ready;
  assign status.emit_last  = (idx == n_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= 6'd32;
      result_valid <= 1'b0;
      depth        <= '0;
      visited      <= '0;
      counter      <= '0;
      for (int r = 0; r < VERTEX_LIMIT; r++) begin
        adj[r] <= '0;
      end
    end else begin
      if (cfg_write) vertex_count <= cfg_data;
      if (result_ready && op != OP_EMIT) result_valid <= 1'b0;
      unique case (op)
        OP_NONE: begin
        end
        OP_ROW_WRITE: begin
          if (row_ok) adj[item.row_index] <= item.row_bits;
        end
        OP_LOAD: begin
          n       <= n_clamp;
          nmask   <= nmask_clamp;
          visited <= '0;
          depth   <= '0;
          fin     <= '0;
        end
        OP_WALK_T: begin
          if (depth == 6'd0) begin
            stack[0]               <= root_pick[4:0];
            top                    <= root_pick[4:0];
            depth                  <= 6'd1;
            visited[root_pick[4:0]] <= 1'b1;
          end else if (open_pick[5]) begin
            stack[depth[4:0]]       <= open_pick[4:0];
            top                     <= open_pick[4:0];
            depth                   <= depth + 6'd1;
            visited[open_pick[4:0]] <= 1'b1;
          end else begin
            // pop and record the finished vertex
            depth           <= depth - 6'd1;
            top             <= below_top;
            finish[fin[4:0]] <= top;
            fin             <= fin + 6'd1;
          end
        end
        OP_INIT2: begin
          visited <= '0;
          ptr     <= n;
          counter <= '0;
        end
        OP_WALK: begin
          if (depth == 6'd0) begin
            // next root in reverse finish order; skip it if already labeled
            ptr <= ptr - 6'd1;
            if (!visited[cand]) begin
              stack[0]      <= cand;
              top           <= cand;
              depth         <= 6'd1;
              visited[cand] <= 1'b1;
              comp[cand]    <= counter[4:0];
              label         <= counter[4:0];
              counter       <= counter + 6'd1;
            end
          end else if (open_pick[5]) begin
            stack[depth[4:0]]       <= open_pick[4:0];
            top                     <= open_pick[4:0];
            depth                   <= depth + 6'd1;
            visited[open_pick[4:0]] <= 1'b1;
            comp[open_pick[4:0]]    <= label;
          end else begin
            depth <= depth - 6'd1;
            top   <= below_top;
          end
        end
        OP_EMIT_INIT: begin
          idx <= '0;
        end
        OP_EMIT: begin
          result_valid           <= 1'b1;
          result.vertex          <= idx;
          result.component       <= comp[idx];
          result.component_total <= counter;
          result.last            <= (idx == n_last);
          idx                    <= idx + 5'd1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/scc_checker.sv]
// Port-level checks for strongly_connected_components, attached by bind.
// Depends on scc_pkg.
module scc_port_assert
  import scc_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         item_valid,
  input logic         item_ready,
  input item_word_t   item,
  input logic         result_valid,
  input logic         result_ready,
  input result_word_t result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.req_type == REQ_COMPUTE |=> !item_ready)
    else $error("item taken right after a compute");

  a_write_quick: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.req_type == REQ_WRITE |=> item_ready)
    else $error("row write did not complete in one cycle");

  a_label_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ({1'b0, result.component} < result.component_total))
    else $error("component number not below component total");

endmodule

bind strongly_connected_components scc_port_assert u_scc_port_assert (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

[test/scc_checker.sv]
`timescale 1ns / 1ps
// Checker for strongly_connected_components: snoops the item, result and config ports,
// labels components on its own copy of the graph and compares every result word.
// Depends on scc_pkg for the word types and request codes.
module scc_checker
  import scc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  logic         item_ready,
  input  item_word_t   item,
  input  logic         result_valid,
  input  logic         result_ready,
  input  result_word_t result,
  input  logic         cfg_write,
  input  logic [5:0]   cfg_data,
  output int           errors,
  output int           pending
);

  localparam int NV = 32;

  logic [31:0]  adj_rows [NV];
  logic [5:0]   vertex_reg;
  logic [31:0]  marked;
  logic [4:0]   finish_seq [NV];
  int           finish_len;
  logic [4:0]   label_of [NV];
  result_word_t expected_labels [$];

  task automatic report(input string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  function automatic int vertices_in_use();
    if (vertex_reg == 0) return 1;
    if (vertex_reg > NV) return NV;
    return int'(vertex_reg);
  endfunction

  // Out-neighbors of v, or in-neighbors when walking the transposed graph.
  function automatic logic [31:0] reach_set(int v, int n, bit transposed);
    logic [31:0] s;
    s = '0;
    if (!transposed) begin
      s = adj_rows[v];
    end else begin
      for (int j = 0; j < n; j++) begin
        if (adj_rows[j][v]) s[j] = 1'b1;
      end
    end
    if (n < 32) s &= (32'd1 << n) - 32'd1;
    return s;
  endfunction

  // Depth-first walk, lowest neighbor first; the transposed walk records finish order.
  function automatic void explore(int root, int n, bit transposed, int label);
    int          stack [$];
    int          top;
    int          j;
    logic [31:0] open;
    marked[root] = 1'b1;
    label_of[root] = 5'(label);
    stack.push_back(root);
    while (stack.size() > 0) begin
      top = stack[$];
      open = reach_set(top, n, transposed) & ~marked;
      if (open != 0) begin
        j = 0;
        while (!open[j]) j++;
        marked[j] = 1'b1;
        label_of[j] = 5'(label);
        stack.push_back(j);
      end else begin
        void'(stack.pop_back());
        if (transposed && finish_len < NV) begin
          finish_seq[finish_len] = 5'(top);
          finish_len++;
        end
      end
    end
  endfunction

  function automatic void label_components();
    int           n;
    int           v;
    int           count;
    result_word_t w;
    n = vertices_in_use();
    finish_len = 0;
    marked = '0;
    for (int i = 0; i < n; i++) begin
      if (!marked[i]) explore(i, n, 1'b1, 0);
    end
    marked = '0;
    count = 0;
    for (int i = n; i > 0; i--) begin
      v = int'(finish_seq[i - 1]);
      if (v < n && !marked[v]) begin
        explore(v, n, 1'b0, count);
        count++;
      end
    end
    for (int i = 0; i < n; i++) begin
      w.vertex          = 5'(i);
      w.component       = label_of[i];
      w.component_total = 6'(count);
      w.last            = (i == n - 1);
      expected_labels.push_back(w);
    end
  endfunction

  task automatic check_result(input result_word_t got);
    result_word_t want;
    if (expected_labels.size() == 0) begin
      report($sformatf("result word for vertex %0d with nothing expected", got.vertex));
    end else begin
      want = expected_labels.pop_front();
      if (got.vertex != want.vertex)
        report($sformatf("vertex %0d, expected %0d", got.vertex, want.vertex));
      if (got.component != want.component)
        report($sformatf("vertex %0d: component %0d, expected %0d",
                         want.vertex, got.component, want.component));
      if (got.component_total != want.component_total)
        report($sformatf("vertex %0d: component_total %0d, expected %0d",
                         want.vertex, got.component_total, want.component_total));
      if (got.last != want.last)
        report($sformatf("vertex %0d: last %0b, expected %0b",
                         want.vertex, got.last, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NV; i++) adj_rows[i] = '0;
      vertex_reg = 6'd32;
      marked = '0;
      expected_labels.delete();
      errors = 0;
    end else begin
      if (cfg_write) vertex_reg = cfg_data;
      if (result_valid && result_ready) check_result(result);
      if (item_valid && item_ready) begin
        if (item.req_type == REQ_WRITE) begin
          adj_rows[item.row_index] = item.row_bits;
        end else begin
          label_components();
        end
      end
    end
    pending = expected_labels.size();
  end

endmodule

[test/strongly_connected_components_test.sv]
`timescale 1ns / 1ps
// Testbench top for strongly_connected_components: drives row writes, computes and
// vertex_count settings with random idling, and gives the verdict from scc_checker.
module strongly_connected_components_test;
  import scc_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEM_TARGET = 430;

  logic         clk;
  logic         rst;
  logic         item_valid;
  logic         item_ready;
  item_word_t   item;
  logic         result_valid;
  logic         result_ready;
  result_word_t result;
  logic         cfg_write;
  logic [5:0]   cfg_data;

  int errors;
  int pending;
  int in_idle_pct;
  int out_idle_pct;
  int hold_cycles;
  int items_sent;
  int cycles;
  int cur_n;

  strongly_connected_components i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  scc_checker i_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Result side: random back-pressure, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        result_ready <= 1'b0;
        hold_cycles--;
      end else begin
        result_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  task automatic send_word(input item_word_t w);
    if (items_sent < 160) begin
      in_idle_pct = 29;
      out_idle_pct = 59;
    end else if (items_sent < 320) begin
      in_idle_pct = 59;
      out_idle_pct = 29;
    end else begin
      in_idle_pct = 0;
      out_idle_pct = 0;
    end
    while ($urandom_range(99) < in_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    do @(posedge clk); while (!item_ready);
    items_sent++;
  endtask

  task automatic send_row(input int r, input logic [31:0] bits);
    item_word_t w;
    w.req_type = REQ_WRITE;
    w.row_index = 5'(r);
    w.row_bits = bits;
    send_word(w);
  endtask

  // Row fields are don't-care on a compute; fill them with noise.
  task automatic send_compute();
    item_word_t w;
    w.req_type = REQ_COMPUTE;
    w.row_index = 5'($urandom);
    w.row_bits = 32'($urandom);
    send_word(w);
  endtask

  // Hold the input until every result word is back and the block has settled.
  task automatic wait_quiet();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_vertices(input logic [5:0] v);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_n = (v == 0) ? 1 : (v > 32) ? 32 : int'(v);
  endtask

  function automatic logic [5:0] pick_count();
    int r;
    r = $urandom_range(9);
    case (r)
      0: return 6'd0;
      1: return 6'd32;
      2: return 6'($urandom_range(33, 63));
      3: return 6'd1;
      4, 5: return 6'($urandom_range(9, 31));
      default: return 6'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic logic [31:0] random_row(input int v);
    logic [31:0] bits;
    case ($urandom_range(6))
      0: bits = '0;
      1: bits = '1;
      2: bits = $urandom;
      3: bits = $urandom & $urandom & $urandom;
      4: bits = 32'd1 << ((v + 1) % cur_n);
      5: bits = 32'd1 << $urandom_range(cur_n - 1);
      default: bits = ($urandom & $urandom) | (32'd1 << v);
    endcase
    return bits;
  endfunction

  initial begin
    int         v;
    int         pick;
    item_word_t noise;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_ready = 1'b0;
    cfg_write = 1'b0;
    cfg_data = '0;
    hold_cycles = 0;
    items_sent = 0;
    in_idle_pct = 29;
    out_idle_pct = 59;
    cur_n = 32;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty graph: every vertex is its own component.
    send_compute();
    // Full rows from both ends of the index range.
    send_row(0, '1);
    send_row(31, '1);
    send_compute();
    // A count of zero acts as one vertex.
    wait_quiet();
    set_vertices(6'd0);
    send_row(0, 32'h8000_0001);
    send_compute();
    wait_quiet();
    set_vertices(6'd1);
    send_compute();
    // Four-vertex ring with garbage above the count, then break it into a chain.
    wait_quiet();
    set_vertices(6'd4);
    for (v = 0; v < 4; v++) send_row(v, 32'hFFFF_FFF0 | (32'd1 << ((v + 1) % 4)));
    send_compute();
    send_row(3, '0);
    send_compute();
    // Oversized count clamps to the full width.
    wait_quiet();
    set_vertices(6'd63);
    send_compute();

    // Stall the result side long enough that the block backs up on its input.
    wait_quiet();
    set_vertices(6'd32);
    hold_cycles = 400;
    send_compute();
    repeat (4) begin
      v = $urandom_range(31);
      send_row(v, random_row(v));
    end

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(3) == 0) begin
        wait_quiet();
        set_vertices(pick_count());
      end
      pick = $urandom_range(9);
      if (pick == 0) begin
        noise.req_type = 1'($urandom);
        noise.row_index = 5'($urandom);
        noise.row_bits = 32'($urandom);
        send_word(noise);
      end else if (pick == 1) begin
        repeat ($urandom_range(1, 3)) send_row($urandom_range(31), $urandom);
      end else begin
        repeat ($urandom_range(1, (cur_n < 6) ? cur_n : 6)) begin
          v = $urandom_range(cur_n - 1);
          send_row(v, random_row(v));
        end
        send_compute();
      end
    end

    wait_quiet();
    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/scc_pkg.sv
rtl/scc_ctrl.sv
rtl/scc_datapath.sv
rtl/strongly_connected_components.sv
rtl/scc_checker.sv
test/scc_checker.sv
test/strongly_connected_components_test.sv
